>>> hdl/txcst_pkg.sv
// Shared types and codes for the transmit completion slot tracker.
// Holds the request/result transfer structs, request and status codes, and defaults.
// No dependencies.
package txcst_pkg;

  localparam int SLOT_COUNT_DEF = 64;
  localparam int MAX_RESULTS    = 64;
  localparam int ADDR_W         = 32;
  localparam int SLOT_W         = 6;

  localparam logic [1:0] REQ_ALLOC    = 2'd0;
  localparam logic [1:0] REQ_COMPLETE = 2'd1;
  localparam logic [1:0] REQ_RECLAIM  = 2'd2;
  localparam logic [1:0] REQ_RELEASE  = 2'd3;

  localparam logic [2:0] ST_GRANTED   = 3'd0;
  localparam logic [2:0] ST_FULL      = 3'd1;
  localparam logic [2:0] ST_RECLAIMED = 3'd2;
  localparam logic [2:0] ST_MISMATCH  = 3'd3;
  localparam logic [2:0] ST_NOTHING   = 3'd4;
  localparam logic [2:0] ST_RECORDED  = 3'd5;
  localparam logic [2:0] ST_RELEASED  = 3'd6;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [ADDR_W-1:0] buffer_address;
    logic [SLOT_W-1:0] slot_index;
  } req_item_t;

  typedef struct packed {
    logic [2:0]        status;
    logic [SLOT_W-1:0] result_slot;
    logic [ADDR_W-1:0] result_address;
    logic              last;
  } rsp_item_t;

endpackage

>>> hdl/tx_completion_slot_tracker.sv
// Transmit completion slot tracker: slot table in two synchronous memories.
// Depends on txcst_pkg (transfer structs, request and status codes).
//
// Usage:
//   req channel (req_valid/req_ready/req) carries one request per transfer:
//   allocate, peer completion write, reclaim, or release. rsp channel
//   (rsp_valid/rsp_ready/rsp) returns result transfers; the final result of a
//   request has last set. Out-of-range completion writes and releases are
//   dropped with no result.
// Request handling:
//   completion write / release: result registered from the single-slot state.
//   allocate: the walk reads one slot per cycle from slot 0 until a free slot
//   or the end of the table.
//   reclaim: the walk reads one slot per cycle through the memory read port,
//   up to MAX_RESULTS results; it holds at a reporting slot while the output stalls.
//   One request is worked on at a time; the next request is taken as soon as
//   the previous one has handed its last result to the output register.
// Reset: all slots read as free and clear at once (per-slot valid flags are
//   cleared); no clearing pass, requests are taken in the cycle after reset.
// Stall: the walk moves on over slots that give no result; at a slot whose
//   result cannot move on while rsp_ready is low, it holds its place and no
//   slot is modified until the output register frees up.
module tx_completion_slot_tracker #(
  parameter int SLOT_COUNT = txcst_pkg::SLOT_COUNT_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  output logic                  req_ready,
  input  txcst_pkg::req_item_t  req,
  output logic                  rsp_valid,
  input  logic                  rsp_ready,
  output txcst_pkg::rsp_item_t  rsp
);
  import txcst_pkg::*;

  localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int CNT_W = $clog2(MAX_RESULTS + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);
  localparam logic [8:0]       SLOT_LIM = 9'(SLOT_COUNT);
  localparam logic [CNT_W-1:0] CNT_STOP = CNT_W'(MAX_RESULTS - 1);
  localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(MAX_RESULTS);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SINGLE = 4'b0010,
    S_SCAN   = 4'b0100,
    S_FLUSH  = 4'b1000
  } state_t;

  state_t state, state_next;

  // Request being worked on
  logic [1:0]        cur_type;
  logic [ADDR_W-1:0] cur_addr;
  logic [IDX_W-1:0]  cur_slot;

  // Table walk
  logic [IDX_W-1:0]  scan_idx;
  logic [CNT_W-1:0]  cnt;
  logic              idx_adv;
  logic              cnt_inc;

  // Reclaim result held back until we know whether it is the final one
  logic              hold_valid;
  rsp_item_t         hold;
  logic              hold_load;
  rsp_item_t         new_item;

  // Slot memories and per-slot valid flags (an invalid slot reads as zero)
  logic [ADDR_W-1:0] pend_mem [SLOT_COUNT];
  logic [ADDR_W-1:0] comp_mem [SLOT_COUNT];
  logic [SLOT_COUNT-1:0] pend_vld, comp_vld;
  logic [ADDR_W-1:0] rd_pend, rd_comp;
  logic              rd_pend_v, rd_comp_v;
  logic              rd_en;
  logic [IDX_W-1:0]  rd_addr;
  logic              pend_we, comp_we, pend_clr, comp_clr;
  logic [IDX_W-1:0]  wr_idx, clr_idx;

  logic [ADDR_W-1:0] p_eff, c_eff;
  logic              elig, match, at_end;

  logic              push, out_space, accept, flush_done;
  rsp_item_t         push_item;

  logic              in_slot_ok;
  logic [IDX_W+SLOT_W-1:0] in_slot_ext;

  function automatic logic [SLOT_W-1:0] slot6(input logic [IDX_W-1:0] i);
    logic [IDX_W+SLOT_W-1:0] ext;
    ext = {{SLOT_W{1'b0}}, i};
    return ext[SLOT_W-1:0];
  endfunction

  assign req_ready   = (state == S_IDLE);
  assign accept      = req_valid && req_ready;
  assign out_space   = !rsp_valid || rsp_ready;
  assign in_slot_ext = {{IDX_W{1'b0}}, req.slot_index};
  assign in_slot_ok  = ({3'b000, req.slot_index} < SLOT_LIM);

  assign p_eff  = rd_pend_v ? rd_pend : '0;
  assign c_eff  = rd_comp_v ? rd_comp : '0;
  assign elig   = (p_eff != '0) && (c_eff != '0);
  assign match  = (p_eff == c_eff);
  assign at_end = (scan_idx == LAST_IDX);

  always_comb begin
    new_item.status         = match ? ST_RECLAIMED : ST_MISMATCH;
    new_item.result_slot    = slot6(scan_idx);
    new_item.result_address = match ? p_eff : c_eff;
    new_item.last           = 1'b0;
  end

  // Control: walk, write-back and result selection
  always_comb begin
    state_next = state;
    push       = 1'b0;
    push_item  = '0;
    rd_en      = 1'b0;
    rd_addr    = IDX_W'(scan_idx + 1'b1);
    idx_adv    = 1'b0;
    cnt_inc    = 1'b0;
    hold_load  = 1'b0;
    pend_we    = 1'b0;
    comp_we    = 1'b0;
    pend_clr   = 1'b0;
    comp_clr   = 1'b0;
    wr_idx     = scan_idx;
    clr_idx    = scan_idx;
    flush_done = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          priority if (req.req_type == REQ_ALLOC || req.req_type == REQ_RECLAIM) begin
            rd_en      = 1'b1;
            rd_addr    = '0;
            state_next = S_SCAN;
          end else if (in_slot_ok) begin
            state_next = S_SINGLE;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      S_SINGLE: begin
        push                     = 1'b1;
        push_item.status         = (cur_type == REQ_COMPLETE) ? ST_RECORDED : ST_RELEASED;
        push_item.result_slot    = slot6(cur_slot);
        push_item.result_address = '0;
        push_item.last           = 1'b1;
        wr_idx                   = cur_slot;
        clr_idx                  = cur_slot;
        if (out_space) begin
          if (cur_type == REQ_COMPLETE) begin
            comp_we = 1'b1;
          end else begin
            pend_clr = 1'b1;
            comp_clr = 1'b1;
          end
          state_next = S_IDLE;
        end
      end
      S_SCAN: begin
        if (cur_type == REQ_ALLOC) begin
          priority if (p_eff == '0) begin
            push                  = 1'b1;
            push_item.status      = ST_GRANTED;
            push_item.result_slot = slot6(scan_idx);
            push_item.last        = 1'b1;
            if (out_space) begin
              pend_we    = 1'b1;
              comp_clr   = 1'b1;
              state_next = S_IDLE;
            end
          end else if (at_end) begin
            push             = 1'b1;
            push_item.status = ST_FULL;
            push_item.last   = 1'b1;
            if (out_space) state_next = S_IDLE;
          end else begin
            rd_en   = 1'b1;
            idx_adv = 1'b1;
          end
        end else begin
          if (elig) begin
            // Send the previous held result on; it is not the final one
            if (hold_valid) begin
              push      = 1'b1;
              push_item = hold;
            end
            if (!hold_valid || out_space) begin
              hold_load = 1'b1;
              cnt_inc   = 1'b1;
              if (match) begin
                pend_clr = 1'b1;
                comp_clr = 1'b1;
              end
              if (cnt == CNT_STOP || at_end) begin
                state_next = S_FLUSH;
              end else begin
                rd_en   = 1'b1;
                idx_adv = 1'b1;
              end
            end
          end else if (at_end) begin
            state_next = S_FLUSH;
          end else begin
            rd_en   = 1'b1;
            idx_adv = 1'b1;
          end
        end
      end
      S_FLUSH: begin
        push = 1'b1;
        if (hold_valid) begin
          push_item      = hold;
          push_item.last = 1'b1;
        end else begin
          push_item.status = ST_NOTHING;
          push_item.last   = 1'b1;
        end
        if (out_space) begin
          flush_done = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      hold_valid <= 1'b0;
      rsp_valid  <= 1'b0;
      pend_vld   <= '0;
      comp_vld   <= '0;
    end else begin
      state <= state_next;
      if (flush_done) begin
        hold_valid <= 1'b0;
      end else if (hold_load) begin
        hold_valid <= 1'b1;
      end
      if (push && out_space) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      if (pend_we)  pend_vld[wr_idx]  <= 1'b1;
      if (comp_we)  comp_vld[wr_idx]  <= 1'b1;
      if (pend_clr) pend_vld[clr_idx] <= 1'b0;
      if (comp_clr) comp_vld[clr_idx] <= 1'b0;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      cur_type <= req.req_type;
      cur_addr <= req.buffer_address;
      cur_slot <= in_slot_ext[IDX_W-1:0];
      scan_idx <= '0;
      cnt      <= '0;
    end else begin
      if (idx_adv) scan_idx <= IDX_W'(scan_idx + 1'b1);
      if (cnt_inc) cnt <= CNT_W'(cnt + 1'b1);
    end
    if (hold_load) hold <= new_item;
    if (push && out_space) rsp <= push_item;
  end

  // Slot memories: one write and one registered read per cycle each
  always_ff @(posedge clk) begin
    if (pend_we) pend_mem[wr_idx] <= cur_addr;
    if (comp_we) comp_mem[wr_idx] <= cur_addr;
    if (rd_en) begin
      rd_pend   <= pend_mem[rd_addr];
      rd_comp   <= comp_mem[rd_addr];
      rd_pend_v <= pend_vld[rd_addr];
      rd_comp_v <= comp_vld[rd_addr];
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_MAX)
    else $error("reclaim result count above limit");

  a_hold_in_reclaim: assert property (@(posedge clk) disable iff (rst)
    hold_valid |-> (state == S_SCAN || state == S_FLUSH))
    else $error("held reclaim result outside reclaim walk");

  a_pend_write_grant: assert property (@(posedge clk) disable iff (rst)
    pend_we |-> (state == S_SCAN && cur_type == REQ_ALLOC && out_space))
    else $error("buffer write outside an allocate grant");

  a_flush_exit: assert property (@(posedge clk) disable iff (rst)
    (state == S_FLUSH && out_space) |=> (state == S_IDLE && !hold_valid && rsp_valid))
    else $error("reclaim did not finish after final result");

endmodule

>>> bench/tb.sv
`timescale 1ns / 100ps
// Self-checking bench for the transmit completion slot tracker.
// Depends on txcst_pkg and tx_completion_slot_tracker; predicts every result internally.
module tb;
  import txcst_pkg::*;

  localparam int SLOTS        = SLOT_COUNT_DEF;
  localparam int LIMIT_CYCLES = 1_000_000;
  localparam int MAX_REPORTS  = 10;

  logic      clk;
  logic      rst;
  logic      req_valid;
  logic      req_ready;
  req_item_t req;
  logic      rsp_valid;
  logic      rsp_ready;
  rsp_item_t rsp;

  // Shadow copy of the slot table, updated at each accepted request.
  logic [ADDR_W-1:0] buf_table [SLOTS];
  logic [ADDR_W-1:0] cpl_table [SLOTS];

  // Results the tracker still owes us, oldest first.
  rsp_item_t due_results[$];

  int send_idle_pct;
  int rsp_stall_pct;
  int ready_hold_cycles;
  int fail_count;
  int cycle_count;

  tx_completion_slot_tracker #(
    .SLOT_COUNT(SLOTS)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp      (rsp)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Abort a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Work out what one accepted request must produce and advance the shadow table.
  task automatic apply_slot_request(input req_item_t item);
    rsp_item_t r;
    int        hits;
    bit        found;
    r     = '0;
    hits  = 0;
    found = 1'b0;
    case (item.req_type)
      REQ_ALLOC: begin
        // Lowest slot with a zero address wins; a zero address keeps it free.
        for (int i = 0; i < SLOTS && !found; i++) begin
          if (buf_table[i] == '0) begin
            found         = 1'b1;
            cpl_table[i]  = '0;
            buf_table[i]  = item.buffer_address;
            r.status      = ST_GRANTED;
            r.result_slot = SLOT_W'(i);
          end
        end
        if (!found) r.status = ST_FULL;
        r.last = 1'b1;
        due_results.push_back(r);
      end
      REQ_COMPLETE: begin
        if (int'(item.slot_index) < SLOTS) begin
          cpl_table[item.slot_index] = item.buffer_address;
          r.status      = ST_RECORDED;
          r.result_slot = item.slot_index;
          r.last        = 1'b1;
          due_results.push_back(r);
        end
      end
      REQ_RECLAIM: begin
        // Walk from slot 0; only slots with both words nonzero report.
        for (int i = 0; i < SLOTS && hits < MAX_RESULTS; i++) begin
          if (cpl_table[i] != '0 && buf_table[i] != '0) begin
            r             = '0;
            r.result_slot = SLOT_W'(i);
            if (cpl_table[i] != buf_table[i]) begin
              r.status         = ST_MISMATCH;
              r.result_address = cpl_table[i];
            end else begin
              r.status         = ST_RECLAIMED;
              r.result_address = buf_table[i];
              buf_table[i]     = '0;
              cpl_table[i]     = '0;
            end
            due_results.push_back(r);
            hits++;
          end
        end
        if (hits == 0) begin
          r        = '0;
          r.status = ST_NOTHING;
          r.last   = 1'b1;
          due_results.push_back(r);
        end else begin
          due_results[due_results.size() - 1].last = 1'b1;
        end
      end
      REQ_RELEASE: begin
        if (int'(item.slot_index) < SLOTS) begin
          buf_table[item.slot_index] = '0;
          cpl_table[item.slot_index] = '0;
          r.status      = ST_RELEASED;
          r.result_slot = item.slot_index;
          r.last        = 1'b1;
          due_results.push_back(r);
        end
      end
      default: ;
    endcase
  endtask

  function automatic req_item_t mk_req(input logic [1:0] kind,
                                       input logic [ADDR_W-1:0] addr,
                                       input int slot);
    req_item_t item;
    item.req_type       = kind;
    item.buffer_address = addr;
    item.slot_index     = SLOT_W'(slot);
    return item;
  endfunction

  // Random busy slot, or -1 when every slot is free.
  function automatic int pick_busy_slot();
    int start;
    int s;
    start = $urandom_range(SLOTS - 1);
    for (int k = 0; k < SLOTS; k++) begin
      s = (start + k) % SLOTS;
      if (buf_table[s] != '0) return s;
    end
    return -1;
  endfunction

  // Offer one request at a falling edge and hold it until the transfer.
  // Return at the next falling edge with valid still high.
  task automatic send_req(input req_item_t item);
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req       <= item;
    req_valid <= 1'b1;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    apply_slot_request(item);
    @(negedge clk);
  endtask

  // Drop valid and wait until every owed result has come back.
  task automatic drain_results();
    req_valid <= 1'b0;
    @(negedge clk);
    while (due_results.size() != 0) @(negedge clk);
  endtask

  // Receiver: random stalls, or a counted hold-off when one is requested.
  initial begin
    rsp_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (ready_hold_cycles > 0) begin
        rsp_ready <= 1'b0;
        ready_hold_cycles = ready_hold_cycles - 1;
      end else begin
        rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
    end
  end

  // Check every result transfer against the oldest owed result.
  always @(posedge clk) begin
    rsp_item_t want;
    if (!rst && rsp_valid && rsp_ready) begin
      if (due_results.size() == 0) begin
        if (fail_count < MAX_REPORTS)
          $display("unexpected result: status %0d slot %0d addr %h last %b",
                   rsp.status, rsp.result_slot, rsp.result_address, rsp.last);
        fail_count++;
      end else begin
        want = due_results.pop_front();
        if (rsp.status !== want.status || rsp.result_slot !== want.result_slot ||
            rsp.result_address !== want.result_address || rsp.last !== want.last) begin
          if (fail_count < MAX_REPORTS)
            $display({"result mismatch: want st %0d slot %0d addr %h last %b,",
                      " got st %0d slot %0d addr %h last %b"},
                     want.status, want.result_slot, want.result_address, want.last,
                     rsp.status, rsp.result_slot, rsp.result_address, rsp.last);
          fail_count++;
        end
      end
    end
  end

  // Corner cases from an empty table: empty reclaim, zero and extreme addresses,
  // mismatch, zero completion word, completion on a free slot, release of a free slot.
  task automatic test_directed();
    send_req(mk_req(REQ_RECLAIM,  32'h0,        0));
    send_req(mk_req(REQ_ALLOC,    32'hFFFFFFFF, 0));
    send_req(mk_req(REQ_ALLOC,    32'h0,        0));
    send_req(mk_req(REQ_ALLOC,    32'h00000001, 0));
    send_req(mk_req(REQ_ALLOC,    32'h80000000, 0));
    send_req(mk_req(REQ_COMPLETE, 32'hFFFFFFFF, 0));
    send_req(mk_req(REQ_COMPLETE, 32'h00000002, 1));
    send_req(mk_req(REQ_COMPLETE, 32'h0,        2));
    send_req(mk_req(REQ_COMPLETE, 32'h5A5A5A5A, SLOTS - 1));
    send_req(mk_req(REQ_RECLAIM,  32'h0,        0));
    send_req(mk_req(REQ_RELEASE,  32'h0,        1));
    send_req(mk_req(REQ_RELEASE,  32'hFFFFFFFF, SLOTS - 1));
    send_req(mk_req(REQ_COMPLETE, 32'h80000000, 2));
    send_req(mk_req(REQ_RECLAIM,  32'h0,        0));
    send_req(mk_req(REQ_ALLOC,    32'h7FFFFFFF, 0));
    send_req(mk_req(REQ_RELEASE,  32'h0,        0));
    send_req(mk_req(REQ_RECLAIM,  32'h0,        0));
    drain_results();
  endtask

  // Fill the whole table behind a long receiver hold-off, overflow it, complete
  // every slot (a few wrongly) and reclaim the lot in one long burst.
  task automatic test_full_table();
    logic [ADDR_W-1:0] a;
    ready_hold_cycles = 400;
    for (int i = 0; i <= SLOTS; i++) begin
      a = $urandom();
      if (a == '0) a = 32'h1;
      send_req(mk_req(REQ_ALLOC, a, 0));
    end
    for (int s = 0; s < SLOTS; s++) begin
      a = buf_table[s];
      if (s % 8 == 3) a = a ^ $urandom_range(1, 255);
      send_req(mk_req(REQ_COMPLETE, a, s));
    end
    send_req(mk_req(REQ_RECLAIM, 32'h0, 0));
    // Only the mismatched slots are left; clear them out.
    send_req(mk_req(REQ_RECLAIM, 32'h0, 0));
    for (int s = 3; s < SLOTS; s += 8)
      send_req(mk_req(REQ_RELEASE, $urandom(), s));
    drain_results();
  endtask

  // Mostly well-formed allocate / complete / reclaim / release traffic on
  // live slots, with some noise on arbitrary slots.
  task automatic test_mixed_traffic(input int count, input int idle_pct, input int stall_pct);
    req_item_t item;
    int        pick;
    int        s;
    send_idle_pct = idle_pct;
    rsp_stall_pct = stall_pct;
    repeat (count) begin
      pick = $urandom_range(99);
      s    = pick_busy_slot();
      item = mk_req(REQ_ALLOC, $urandom(), $urandom_range(SLOTS - 1));
      if (pick < 28) begin
        if ($urandom_range(9) == 0) item.buffer_address = '0;
      end else if (pick < 56) begin
        item.req_type = REQ_COMPLETE;
        if (s >= 0) begin
          item.slot_index = SLOT_W'(s);
          if ($urandom_range(4) != 0) item.buffer_address = buf_table[s];
        end
      end else if (pick < 76) begin
        item.req_type = REQ_RECLAIM;
      end else if (pick < 88) begin
        item.req_type = REQ_RELEASE;
        if (s >= 0) item.slot_index = SLOT_W'(s);
      end else begin
        item.req_type = ($urandom_range(1) == 0) ? REQ_COMPLETE : REQ_RELEASE;
      end
      send_req(item);
    end
    drain_results();
  endtask

  initial begin
    rst               = 1'b1;
    req_valid         = 1'b0;
    req               = '0;
    send_idle_pct     = 0;
    rsp_stall_pct     = 0;
    ready_hold_cycles = 0;
    fail_count        = 0;
    cycle_count       = 0;
    for (int i = 0; i < SLOTS; i++) begin
      buf_table[i] = '0;
      cpl_table[i] = '0;
    end
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_directed();
    send_idle_pct = 27;
    rsp_stall_pct = 27;
    test_full_table();
    test_mixed_traffic(19, 0, 0);
    test_mixed_traffic(19, 69, 0);
    test_mixed_traffic(19, 0, 69);
    test_mixed_traffic(19, 27, 27);

    // Let a full table walk pass to catch stray results.
    repeat (SLOTS + 8) @(posedge clk);
    if (fail_count == 0 && due_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

>>> sim.f
hdl/txcst_pkg.sv
hdl/tx_completion_slot_tracker.sv
bench/tb.sv
